/* design/ppt_pkg.sv */
// Shared types and constants for the photogate period timer.
// No dependencies; imported by every module of the block.
package ppt_pkg;

   localparam int LEVEL_W  = 10;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = TIME_W + 1;
   localparam int REP_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_US       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOGGLE_PERIOD_US = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPETITIONS      = 2'd3;

   localparam logic [LEVEL_W-1:0] RST_DARK_THRESHOLD   = 10'd512;
   localparam logic [TIME_W-1:0]  RST_LOCKOUT_US       = 32'd100000;
   localparam logic [TIME_W-1:0]  RST_TOGGLE_PERIOD_US = 32'd5000000;
   localparam logic [REP_W-1:0]   RST_REPETITIONS      = 8'd10;

   localparam logic [REP_W-1:0]   PERIOD_COUNT_MAX     = 8'd255;

   typedef struct packed {
      logic [LEVEL_W-1:0] dark_threshold;
      logic [TIME_W-1:0]  lockout_us;
      logic [TIME_W-1:0]  toggle_period_us;
      logic [REP_W-1:0]   repetitions;
   } cfg_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_us;
      logic                period_valid;
      logic                magnet_on;
      logic                done_res;
   } result_type;

endpackage

/* design/ppt_csr.sv */
// Configuration registers of the photogate period timer.
// Depends on ppt_pkg for register indexes, reset values and cfg_type.
module ppt_csr import ppt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DARK_THRESHOLD:   cfg_in.dark_threshold   = csr_wdata[LEVEL_W-1:0];
            CSR_LOCKOUT_US:       cfg_in.lockout_us       = csr_wdata[TIME_W-1:0];
            CSR_TOGGLE_PERIOD_US: cfg_in.toggle_period_us = csr_wdata[TIME_W-1:0];
            CSR_REPETITIONS:      cfg_in.repetitions      = csr_wdata[REP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold   <= RST_DARK_THRESHOLD;
         cfg_ff.lockout_us       <= RST_LOCKOUT_US;
         cfg_ff.toggle_period_us <= RST_TOGGLE_PERIOD_US;
         cfg_ff.repetitions      <= RST_REPETITIONS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/ppt_step.sv */
// Per-tick detection, period and magnet logic with its timing state.
// Depends on ppt_pkg for cfg_type and result_type.
module ppt_step import ppt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               fire,
   input  logic [LEVEL_W-1:0] light_level,
   output result_type         result
);

   logic [TIME_W-1:0] tick_ff, tick_in;
   logic [TIME_W-1:0] last_accept_ff, last_accept_in;
   logic [TIME_W-1:0] first_edge_ff, first_edge_in;
   logic              edge_phase_ff, edge_phase_in;
   logic [REP_W-1:0]  period_count_ff, period_count_in;
   logic              magnet_ff, magnet_in;
   logic [TIME_W-1:0] last_toggle_ff, last_toggle_in;
   logic              stopped_ff, stopped_in;

   logic [TIME_W-1:0] since_accept;
   logic [TIME_W-1:0] since_toggle;
   logic [TIME_W-1:0] edge_diff;
   logic              detect;

   assign since_accept = tick_ff - last_accept_ff;
   assign since_toggle = tick_ff - last_toggle_ff;
   assign edge_diff    = tick_ff - first_edge_ff;
   assign detect = (light_level < cfg.dark_threshold) && (since_accept > cfg.lockout_us);

   always_comb begin
      tick_in         = tick_ff + TIME_W'(1);
      last_accept_in  = last_accept_ff;
      first_edge_in   = first_edge_ff;
      edge_phase_in   = edge_phase_ff;
      period_count_in = period_count_ff;
      magnet_in       = magnet_ff;
      last_toggle_in  = last_toggle_ff;
      stopped_in      = stopped_ff;
      result          = '0;

      if (!stopped_ff) begin
         if (detect) begin
            last_accept_in = tick_ff;
            if (!edge_phase_ff) begin
               first_edge_in = tick_ff;
               edge_phase_in = 1'b1;
            end else begin
               result.period_us    = {edge_diff, 1'b0};
               result.period_valid = 1'b1;
               edge_phase_in       = 1'b0;
               if (period_count_ff != PERIOD_COUNT_MAX) begin
                  period_count_in = period_count_ff + REP_W'(1);
               end
            end
         end
         if (since_toggle > cfg.toggle_period_us) begin
            last_toggle_in = tick_ff;
            magnet_in      = !magnet_ff;
         end
         // stop test sees the count after this tick's measurement
         if (period_count_in >= cfg.repetitions) begin
            magnet_in  = 1'b0;
            stopped_in = 1'b1;
         end
      end

      result.magnet_on = stopped_in ? 1'b0 : magnet_in;
      result.done_res  = stopped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         last_accept_ff  <= '0;
         first_edge_ff   <= '0;
         edge_phase_ff   <= 1'b0;
         period_count_ff <= '0;
         magnet_ff       <= 1'b0;
         last_toggle_ff  <= '0;
         stopped_ff      <= 1'b0;
      end else if (fire) begin
         tick_ff         <= tick_in;
         last_accept_ff  <= last_accept_in;
         first_edge_ff   <= first_edge_in;
         edge_phase_ff   <= edge_phase_in;
         period_count_ff <= period_count_in;
         magnet_ff       <= magnet_in;
         last_toggle_ff  <= last_toggle_in;
         stopped_ff      <= stopped_in;
      end
   end

endmodule

/* design/ppt_out_reg.sv */
// Result register of the photogate period timer, one entry with valid/ready.
// Depends on ppt_pkg for result_type.
module ppt_out_reg import ppt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_load,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // take a new result when empty or when the held one transfers now
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* design/photogate_period_timer_top.sv */
// Photogate period timer: light samples in, one result per sample out.
// Path: a sample passes the input register, then the result register, and
// rsp_valid rises once it is held there; a held result not taken stalls it;
// throughput: one sample per cycle while results are taken, set by the
// single-pass step logic between the two registers.
// Reset (synchronous): clears timing state, empties both registers and
// loads the default configuration.
module photogate_period_timer_top import ppt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LEVEL_W-1:0]    req_light_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PERIOD_W-1:0]   rsp_period_us,
   output logic                  rsp_period_valid,
   output logic                  rsp_magnet_on,
   output logic                  rsp_done_res,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type step_result;
   result_type rsp_data;

   logic               in_valid_ff, in_valid_in;
   logic [LEVEL_W-1:0] in_level_ff, in_level_in;
   logic               can_load;
   logic               fire;

   assign fire      = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || can_load;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_level_in = in_level_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_level_in = req_light_level;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_level_ff <= in_level_in;
   end

   ppt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppt_step u_step (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .fire        (fire),
      .light_level (in_level_ff),
      .result      (step_result)
   );

   ppt_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (step_result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_period_us    = rsp_data.period_us;
   assign rsp_period_valid = rsp_data.period_valid;
   assign rsp_magnet_on    = rsp_data.magnet_on;
   assign rsp_done_res     = rsp_data.done_res;

endmodule
